// ===== hdl/mt_gen_pkg.sv =====
`timescale 1ns / 1ps

package mt_gen_pkg;

    localparam int unsigned STATE_WORDS = 624;
    localparam int unsigned SHIFT_DIST  = 397;
    localparam int unsigned IDX_W       = $clog2(STATE_WORDS);
    localparam int unsigned RIDX_W      = $clog2(STATE_WORDS + 2);

    localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] SEED_MULT    = 32'd69069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;

    localparam logic [0:0] REQ_DRAW = 1'b0;
    localparam logic [0:0] REQ_SEED = 1'b1;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0]  WRAP_IDX    = IDX_W'(STATE_WORDS - SHIFT_DIST);
    localparam logic [IDX_W-1:0]  FAR_OFFSET  = IDX_W'(SHIFT_DIST);
    localparam logic [RIDX_W-1:0] USED_UP     = RIDX_W'(STATE_WORDS);
    localparam logic [RIDX_W-1:0] NEVER_SEEDED = RIDX_W'(STATE_WORDS + 1);

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        begin
            y = y_in;
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        end
    endfunction

    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] v;
        begin
            y = {cur[31], nxt[30:0]};
            v = far ^ (y >> 1);
            if (y[0])
            begin
                v = v ^ TWIST_XOR;
            end
            return v;
        end
    endfunction

endpackage

// ===== hdl/mersenne_twister_generator_top.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | req_type, seed_value
// out     | output    | out_valid/ out_stall| random_word
//
// A draw when the state still has unused words passes through accept, memory read and temper.
// A draw that finds the state used up first twists all 624 words through the two-read-port
// state memory, reading then writing each word; a first draw with no seed also seeds first.
// A reseed writes one state word per cycle.
// Reset marks the generator as never seeded; the state memory itself is not cleared.
// The block holds a finished word in its output register while out_stall is high and
// stalls a new draw only at its last cycle while that register is still full.

module mersenne_twister_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [0:0]  req_type,
    input  logic [31:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_word
);
    import mt_gen_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SEED   = 7'b0000010,
        ST_TW_RD0 = 7'b0000100,
        ST_TW_RD  = 7'b0001000,
        ST_TW_WR  = 7'b0010000,
        ST_DR_RD  = 7'b0100000,
        ST_DR_OUT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [RIDX_W-1:0] read_index_reg, read_index_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              draw_pending_reg, draw_pending_next;
    logic [31:0]       val_reg, val_next;
    logic [31:0]       cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       word_reg, word_next;

    logic [31:0]       mem [STATE_WORDS];
    logic [31:0]       rda_reg;
    logic [31:0]       rdb_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [31:0]       wr_data;
    logic              in_take;
    logic              out_free;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rda_reg <= mem[addr_a];
            rdb_reg <= mem[addr_b];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        read_index_next   = read_index_reg;
        idx_next          = idx_reg;
        draw_pending_next = draw_pending_reg;
        val_next          = val_reg;
        cur_next          = cur_reg;
        word_next         = word_reg;
        out_valid_next    = out_valid_reg && out_stall;
        rd_en             = 1'b0;
        addr_a            = idx_reg;
        addr_b            = (idx_reg < WRAP_IDX) ? idx_reg + FAR_OFFSET : idx_reg - WRAP_IDX;
        wr_en             = 1'b0;
        wr_addr           = idx_reg;
        wr_data           = val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    idx_next = '0;
                    if (req_type == REQ_SEED)
                    begin
                        val_next          = seed_value;
                        draw_pending_next = 1'b0;
                        state_next        = ST_SEED;
                    end
                    else if (read_index_reg == NEVER_SEEDED)
                    begin
                        val_next          = DEFAULT_SEED;
                        draw_pending_next = 1'b1;
                        state_next        = ST_SEED;
                    end
                    else if (read_index_reg == USED_UP)
                    begin
                        state_next = ST_TW_RD0;
                    end
                    else
                    begin
                        state_next = ST_DR_RD;
                    end
                end
            end
            ST_SEED:
            begin
                wr_en    = 1'b1;
                val_next = 32'(val_reg * SEED_MULT);
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next        = '0;
                    read_index_next = USED_UP;
                    state_next      = draw_pending_reg ? ST_TW_RD0 : ST_IDLE;
                end
            end
            ST_TW_RD0:
            begin
                rd_en      = 1'b1;
                addr_a     = '0;
                state_next = ST_TW_RD;
            end
            ST_TW_RD:
            begin
                if (idx_reg == '0)
                begin
                    cur_next = rda_reg;
                end
                rd_en      = 1'b1;
                addr_a     = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                state_next = ST_TW_WR;
            end
            ST_TW_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = twist_word(cur_reg, rda_reg, rdb_reg);
                cur_next = rda_reg;
                if (idx_reg == LAST_IDX)
                begin
                    read_index_next = '0;
                    state_next      = ST_DR_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_TW_RD;
                end
            end
            ST_DR_RD:
            begin
                rd_en      = 1'b1;
                addr_a     = read_index_reg[IDX_W-1:0];
                state_next = ST_DR_OUT;
            end
            ST_DR_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    word_next       = temper(rda_reg);
                    read_index_next = read_index_reg + RIDX_W'(1);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            read_index_reg   <= NEVER_SEEDED;
            idx_reg          <= '0;
            draw_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            read_index_reg   <= read_index_next;
            idx_reg          <= idx_next;
            draw_pending_reg <= draw_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        cur_reg  <= cur_next;
        word_reg <= word_next;
    end

endmodule

// ===== tb/sv/mersenne_twister_generator_top_tb.sv =====
`timescale 1ns / 1ps

module mersenne_twister_generator_top_tb;

    import mt_gen_pkg::REQ_DRAW;
    import mt_gen_pkg::REQ_SEED;

    localparam int unsigned POOL_SIZE  = 624;
    localparam int unsigned FAR_STEP   = 397;
    localparam logic [31:0] MAG_XOR    = 32'h9908_b0df;
    localparam logic [31:0] MASK_B     = 32'h9d2c_5680;
    localparam logic [31:0] MASK_C     = 32'hefc6_0000;
    localparam logic [31:0] LCG_MULT   = 32'd69069;
    localparam logic [31:0] BOOT_SEED  = 32'd4357;
    localparam int          ITEM_GOAL  = 1900;
    localparam int          DRAIN_WAIT = 2000;

    typedef struct {
        logic [0:0]  kind;
        logic [31:0] seed;
        bit          hold;
    } mt_request_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [0:0]  req_type;
    logic [31:0] seed_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] random_word;

    mt_request_t pending_requests[$];
    logic [31:0] expected_words[$];
    int          error_count;
    int          beats_taken;
    int          words_seen;

    logic [31:0] pool_words[POOL_SIZE];
    int unsigned pool_pos;

    mt_request_t next_req;
    logic [31:0] want_word;

    mersenne_twister_generator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    always #2 clk = ~clk;

    function automatic void fill_pool(input logic [31:0] s);
        pool_words[0] = s;
        for (int i = 1; i < POOL_SIZE; i++)
        begin
            pool_words[i] = pool_words[i-1] * LCG_MULT;
        end
        pool_pos = POOL_SIZE;
    endfunction

    function automatic void regenerate_pool();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            y = {pool_words[k][31], pool_words[(k + 1) % POOL_SIZE][30:0]};
            v = pool_words[(k + FAR_STEP) % POOL_SIZE] ^ (y >> 1);
            if (y[0])
            begin
                v = v ^ MAG_XOR;
            end
            pool_words[k] = v;
        end
        pool_pos = 0;
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] w);
        logic [31:0] t;
        t = w;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & MASK_B);
        t = t ^ ((t << 15) & MASK_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    function automatic logic [31:0] next_word();
        logic [31:0] w;
        if (pool_pos >= POOL_SIZE)
        begin
            if (pool_pos != POOL_SIZE)
            begin
                fill_pool(BOOT_SEED);
            end
            regenerate_pool();
        end
        w = scramble_word(pool_words[pool_pos]);
        pool_pos++;
        return w;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic add_req(input logic [0:0] kind, input logic [31:0] seed, input bit hold);
        mt_request_t r;
        r.kind = kind;
        r.seed = seed;
        r.hold = hold;
        pending_requests.push_back(r);
    endtask

    // The driver presents a new beat only when the line is free, so a stalled beat never changes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            req_type   <= REQ_DRAW;
            seed_value <= 32'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                beats_taken++;
                if (req_type == REQ_SEED)
                begin
                    fill_pool(seed_value);
                end
                else
                begin
                    expected_words.push_back(next_word());
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() > 0
                    && !(pending_requests[0].hold && expected_words.size() > 0)
                    && ((beats_taken >= 800 && beats_taken < 1200)
                        || $urandom_range(0, 99) >= 9))
                begin
                    next_req = pending_requests.pop_front();
                    in_valid   <= 1'b1;
                    req_type   <= next_req.kind;
                    seed_value <= next_req.seed;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected word %08h", random_word));
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (random_word !== want_word)
                    begin
                        note_mismatch($sformatf("word %0d: got %08h, expected %08h",
                                                words_seen, random_word, want_word));
                    end
                end
            end
            out_stall <= !(words_seen >= 300 && words_seen < 700)
                         && ($urandom_range(0, 99) < 9);
        end
    end

    initial
    begin
        int pick;
        int run_len;
        int segments;
        logic [31:0] s;
        clk         = 1'b0;
        rst_n       = 1'b0;
        error_count = 0;
        beats_taken = 0;
        words_seen  = 0;
        pool_pos    = POOL_SIZE + 1;
        segments    = 0;

        // The first draw finds the generator never seeded.
        add_req(REQ_DRAW, $urandom, 1'b0);
        add_req(REQ_DRAW, 32'hffff_ffff, 1'b0);
        add_req(REQ_DRAW, 32'd0, 1'b0);
        add_req(REQ_SEED, 32'd0, 1'b0);
        add_req(REQ_DRAW, $urandom, 1'b0);
        add_req(REQ_DRAW, $urandom, 1'b0);
        add_req(REQ_SEED, 32'hffff_ffff, 1'b0);
        add_req(REQ_DRAW, 32'hffff_ffff, 1'b0);
        add_req(REQ_DRAW, 32'd0, 1'b0);
        add_req(REQ_SEED, BOOT_SEED, 1'b0);
        add_req(REQ_DRAW, $urandom, 1'b0);
        add_req(REQ_SEED, 32'd1, 1'b0);
        add_req(REQ_SEED, 32'h8000_0000, 1'b0);
        add_req(REQ_DRAW, $urandom, 1'b0);
        add_req(REQ_DRAW, $urandom, 1'b0);
        add_req(REQ_SEED, 32'haaaa_aaaa, 1'b1);
        add_req(REQ_SEED, 32'h5555_5555, 1'b0);
        add_req(REQ_DRAW, $urandom, 1'b0);
        add_req(REQ_DRAW, $urandom, 1'b1);

        // A long run of draws uses up the state twice without any reseed.
        for (int i = 0; i < 1300; i++)
        begin
            add_req(REQ_DRAW, $urandom, 1'b0);
        end

        while (pending_requests.size() < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 99);
            segments++;
            if (pick < 70)
            begin
                pick = $urandom_range(0, 99);
                s = (pick < 4) ? 32'd0 : (pick < 8) ? 32'hffff_ffff : $urandom;
                add_req(REQ_SEED, s, (segments % 10) == 0);
                run_len = $urandom_range(1, 30);
                for (int i = 0; i < run_len; i++)
                begin
                    add_req(REQ_DRAW, $urandom, 1'b0);
                end
            end
            else if (pick < 85)
            begin
                run_len = $urandom_range(1, 20);
                for (int i = 0; i < run_len; i++)
                begin
                    add_req(REQ_DRAW, $urandom, (i == 0) && (segments % 10) == 0);
                end
            end
            else
            begin
                run_len = $urandom_range(2, 3);
                for (int i = 0; i < run_len; i++)
                begin
                    add_req(REQ_SEED, $urandom, 1'b0);
                end
                run_len = $urandom_range(0, 3);
                for (int i = 0; i < run_len; i++)
                begin
                    add_req(REQ_DRAW, $urandom, 1'b0);
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_words.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TIMEOUT at %0t with %0d words outstanding", $time, expected_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
